[design/pbdi_pkg.sv]
`timescale 1ns / 1ps

package pbdi_pkg;

    // Controller modes, as shown on mode_now
    localparam logic [2:0] MODE_LAMPTEST = 3'd0;
    localparam logic [2:0] MODE_STARTUP  = 3'd1;
    localparam logic [2:0] MODE_STANDBY  = 3'd2;
    localparam logic [2:0] MODE_CLEANING = 3'd3;
    localparam logic [2:0] MODE_A2B      = 3'd4;
    localparam logic [2:0] MODE_B2A      = 3'd5;

    // Bit positions in the output level word
    localparam int OB_LOCK_A = 0;
    localparam int OB_LOCK_B = 1;
    localparam int OB_FAN    = 2;
    localparam int OB_AE     = 3;
    localparam int OB_AD     = 4;
    localparam int OB_BE     = 5;
    localparam int OB_BD     = 6;

    // Output word after reset: fan and all lamps on, locks off
    localparam logic [6:0] OUT_RESET = 7'h7C;

    // Configuration register indexes
    localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [2:0] REG_TICKS_PER_S  = 3'd1;
    localparam logic [2:0] REG_XFER_FAN     = 3'd2;
    localparam logic [2:0] REG_CLEAN_FAN    = 3'd3;
    localparam logic [2:0] REG_OPEN_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_LAMP_TEST    = 3'd5;
    localparam logic [2:0] REG_RELOCK_DELAY = 3'd6;

    // Configuration reset values
    localparam logic [4:0] DEBOUNCE_RST     = 5'd25;
    localparam logic [5:0] TICKS_PER_S_RST  = 6'd50;
    localparam logic [6:0] XFER_FAN_RST     = 7'd30;
    localparam logic [6:0] CLEAN_FAN_RST    = 7'd120;
    localparam logic [3:0] OPEN_TIMEOUT_RST = 4'd10;
    localparam logic [1:0] LAMP_TEST_RST    = 2'd2;
    localparam logic [4:0] RELOCK_DELAY_RST = 5'd25;

    // Number of debounced inputs
    localparam int NUM_INPUTS = 5;

    // Debounced input positions
    localparam int IN_GA = 0;
    localparam int IN_GB = 1;
    localparam int IN_RED = 2;
    localparam int IN_SA = 3;
    localparam int IN_SB = 4;

    typedef struct packed {
        logic [4:0] debounce_samples;
        logic [5:0] ticks_per_second;
        logic [6:0] transfer_fan_seconds;
        logic [6:0] clean_fan_seconds;
        logic [3:0] open_timeout_seconds;
        logic [1:0] lamp_test_seconds;
        logic [4:0] relock_delay_ticks;
    } cfg_t;

    // Lamp test time reload from a configuration write
    typedef struct packed {
        logic       en;
        logic [1:0] value;
    } lt_load_t;

endpackage

[design/pbdi_debounce.sv]
`timescale 1ns / 1ps

module pbdi_debounce (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic [pbdi_pkg::NUM_INPUTS-1:0]    raw,
    input  logic [4:0]                         samples,
    output logic [pbdi_pkg::NUM_INPUTS-1:0]    level_next
);

    logic [4:0]                      cnt_reg  [pbdi_pkg::NUM_INPUTS];
    logic [4:0]                      cnt_next [pbdi_pkg::NUM_INPUTS];
    logic [pbdi_pkg::NUM_INPUTS-1:0] run_reg;
    logic [pbdi_pkg::NUM_INPUTS-1:0] run_next;
    logic [pbdi_pkg::NUM_INPUTS-1:0] level_reg;
    logic [4:0]                      samples_min1;

    assign samples_min1 = (samples == 5'd0) ? 5'd1 : samples;

    // Count down each lane while its sample differs from the accepted level
    always_comb
    begin
        for (int i = 0; i < pbdi_pkg::NUM_INPUTS; i++)
        begin
            cnt_next[i]   = cnt_reg[i];
            run_next[i]   = run_reg[i];
            level_next[i] = level_reg[i];
            if (raw[i] == level_reg[i])
            begin
                run_next[i] = 1'b0;
            end
            else
            begin
                if (!run_reg[i])
                begin
                    cnt_next[i] = samples_min1;
                end
                cnt_next[i] = cnt_next[i] - 5'd1;
                if (cnt_next[i] == 5'd0)
                begin
                    run_next[i]   = 1'b0;
                    level_next[i] = raw[i];
                end
                else
                begin
                    run_next[i] = 1'b1;
                end
            end
        end
    end

    // Advance lane state once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pbdi_pkg::NUM_INPUTS; i++)
            begin
                cnt_reg[i] <= 5'd0;
            end
            run_reg   <= '0;
            level_reg <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < pbdi_pkg::NUM_INPUTS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            run_reg   <= run_next;
            level_reg <= level_next;
        end
    end

endmodule

[design/pbdi_ctrl.sv]
`timescale 1ns / 1ps

module pbdi_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic [pbdi_pkg::NUM_INPUTS-1:0]    levels,
    input  pbdi_pkg::cfg_t                     cfg,
    input  pbdi_pkg::lt_load_t                 lt_load,
    output logic [6:0]                         out_levels,
    output logic [2:0]                         mode
);

    logic [2:0] mode_reg, mode_next;
    logic [6:0] ol_reg, ol_next;
    logic [5:0] td_reg, td_next;
    logic [6:0] fan_reg, fan_next;
    logic [3:0] to_reg, to_next;
    logic       arm_reg, arm_next;
    logic [1:0] lt_reg, lt_next;
    logic       dwo_reg, dwo_next;
    logic [4:0] rl_reg, rl_next;

    logic [5:0] tps_min1;
    logic [6:0] xfer_fan_min1;
    logic [6:0] clean_fan_min1;
    logic [3:0] timeout_min1;
    logic       second;
    logic       ga, gb, red, sa, sb;
    logic       door;

    assign tps_min1       = (cfg.ticks_per_second == 6'd0) ? 6'd1 : cfg.ticks_per_second;
    assign xfer_fan_min1  = (cfg.transfer_fan_seconds == 7'd0) ? 7'd1
                                                               : cfg.transfer_fan_seconds;
    assign clean_fan_min1 = (cfg.clean_fan_seconds == 7'd0) ? 7'd1 : cfg.clean_fan_seconds;
    assign timeout_min1   = (cfg.open_timeout_seconds == 4'd0) ? 4'd1
                                                               : cfg.open_timeout_seconds;

    assign ga  = levels[pbdi_pkg::IN_GA];
    assign gb  = levels[pbdi_pkg::IN_GB];
    assign red = levels[pbdi_pkg::IN_RED];
    assign sa  = levels[pbdi_pkg::IN_SA];
    assign sb  = levels[pbdi_pkg::IN_SB];

    // One tick: seconds timers, relock countdown, then mode logic
    always_comb
    begin
        mode_next = mode_reg;
        ol_next   = ol_reg;
        fan_next  = fan_reg;
        to_next   = to_reg;
        arm_next  = arm_reg;
        lt_next   = lt_reg;
        dwo_next  = dwo_reg;
        rl_next   = rl_reg;
        door      = 1'b0;

        // Divide ticks into seconds
        td_next = td_reg + 6'd1;
        second  = 1'b0;
        if (td_next >= tps_min1)
        begin
            td_next = 6'd0;
            second  = 1'b1;
        end

        if (second)
        begin
            // Fan run expiry always drops back to standby
            if (fan_next != 7'd0)
            begin
                fan_next = fan_next - 7'd1;
                if (fan_next == 7'd0)
                begin
                    ol_next[pbdi_pkg::OB_FAN] = 1'b0;
                    ol_next[pbdi_pkg::OB_AD]  = 1'b0;
                    ol_next[pbdi_pkg::OB_BD]  = 1'b0;
                    mode_next = pbdi_pkg::MODE_STANDBY;
                end
            end
            // Lamp test countdown
            if (mode_next == pbdi_pkg::MODE_LAMPTEST)
            begin
                if (lt_next <= 2'd1)
                begin
                    lt_next = 2'd0;
                    ol_next[pbdi_pkg::OB_AE]  = 1'b0;
                    ol_next[pbdi_pkg::OB_AD]  = 1'b0;
                    ol_next[pbdi_pkg::OB_BE]  = 1'b0;
                    ol_next[pbdi_pkg::OB_BD]  = 1'b0;
                    ol_next[pbdi_pkg::OB_FAN] = 1'b0;
                    mode_next = pbdi_pkg::MODE_STARTUP;
                end
                else
                begin
                    lt_next = lt_next - 2'd1;
                end
            end
            // Open timeout relocks both doors
            if (to_next != 4'd0 && arm_next)
            begin
                to_next = to_next - 4'd1;
                if (to_next == 4'd0)
                begin
                    ol_next[pbdi_pkg::OB_AE]     = 1'b0;
                    ol_next[pbdi_pkg::OB_AD]     = 1'b0;
                    ol_next[pbdi_pkg::OB_BE]     = 1'b0;
                    ol_next[pbdi_pkg::OB_BD]     = 1'b0;
                    ol_next[pbdi_pkg::OB_LOCK_A] = 1'b1;
                    ol_next[pbdi_pkg::OB_LOCK_B] = 1'b1;
                    ol_next[pbdi_pkg::OB_FAN]    = 1'b0;
                    mode_next = pbdi_pkg::MODE_STANDBY;
                end
            end
        end

        // Relock countdown engages both magnets at its end
        if (rl_next != 5'd0)
        begin
            rl_next = rl_next - 5'd1;
            if (rl_next == 5'd0)
            begin
                ol_next[pbdi_pkg::OB_LOCK_A] = 1'b1;
                ol_next[pbdi_pkg::OB_LOCK_B] = 1'b1;
                dwo_next = 1'b1;
                arm_next = 1'b0;
            end
        end

        // Startup door check
        if (mode_next == pbdi_pkg::MODE_STARTUP)
        begin
            if (sa || sb)
            begin
                ol_next[pbdi_pkg::OB_AE] = sa;
                ol_next[pbdi_pkg::OB_AD] = 1'b1;
                ol_next[pbdi_pkg::OB_BE] = sb;
                ol_next[pbdi_pkg::OB_BD] = 1'b1;
                dwo_next = 1'b1;
            end
            else if (dwo_next)
            begin
                ol_next[pbdi_pkg::OB_AE]  = 1'b0;
                ol_next[pbdi_pkg::OB_AD]  = 1'b1;
                ol_next[pbdi_pkg::OB_BE]  = 1'b0;
                ol_next[pbdi_pkg::OB_BD]  = 1'b1;
                ol_next[pbdi_pkg::OB_FAN] = 1'b1;
                fan_next  = xfer_fan_min1;
                mode_next = pbdi_pkg::MODE_STANDBY;
            end
            else
            begin
                mode_next = pbdi_pkg::MODE_STANDBY;
            end
            ol_next[pbdi_pkg::OB_LOCK_A] = 1'b1;
            ol_next[pbdi_pkg::OB_LOCK_B] = 1'b1;
        end

        // Red button starts a cleaning cycle
        if (red && mode_next == pbdi_pkg::MODE_STANDBY)
        begin
            ol_next[pbdi_pkg::OB_FAN] = 1'b1;
            ol_next[pbdi_pkg::OB_AD]  = 1'b1;
            ol_next[pbdi_pkg::OB_BD]  = 1'b1;
            fan_next  = clean_fan_min1;
            mode_next = pbdi_pkg::MODE_CLEANING;
        end

        // Green buttons release one door, side A first
        if (ga && mode_next == pbdi_pkg::MODE_STANDBY)
        begin
            ol_next[pbdi_pkg::OB_AE]     = 1'b1;
            ol_next[pbdi_pkg::OB_BD]     = 1'b1;
            ol_next[pbdi_pkg::OB_LOCK_A] = 1'b0;
            mode_next = pbdi_pkg::MODE_A2B;
            dwo_next  = 1'b0;
            to_next   = timeout_min1;
            arm_next  = 1'b1;
        end
        if (gb && mode_next == pbdi_pkg::MODE_STANDBY)
        begin
            ol_next[pbdi_pkg::OB_BE]     = 1'b1;
            ol_next[pbdi_pkg::OB_AD]     = 1'b1;
            ol_next[pbdi_pkg::OB_LOCK_B] = 1'b0;
            mode_next = pbdi_pkg::MODE_B2A;
            dwo_next  = 1'b0;
            to_next   = timeout_min1;
            arm_next  = 1'b1;
        end

        // Watch the released door during a transfer
        if (mode_next == pbdi_pkg::MODE_A2B || mode_next == pbdi_pkg::MODE_B2A)
        begin
            door = (mode_next == pbdi_pkg::MODE_A2B) ? sa : sb;
            if (door && !dwo_next && rl_next == 5'd0)
            begin
                arm_next = 1'b0;
                if (cfg.relock_delay_ticks == 5'd0)
                begin
                    ol_next[pbdi_pkg::OB_LOCK_A] = 1'b1;
                    ol_next[pbdi_pkg::OB_LOCK_B] = 1'b1;
                    dwo_next = 1'b1;
                    arm_next = 1'b0;
                end
                else
                begin
                    rl_next = cfg.relock_delay_ticks;
                end
            end
            // Door closed again: run decontamination
            if (!door && dwo_next)
            begin
                dwo_next = 1'b0;
                ol_next[pbdi_pkg::OB_AE]  = 1'b0;
                ol_next[pbdi_pkg::OB_AD]  = 1'b1;
                ol_next[pbdi_pkg::OB_BE]  = 1'b0;
                ol_next[pbdi_pkg::OB_BD]  = 1'b1;
                ol_next[pbdi_pkg::OB_FAN] = 1'b1;
                fan_next  = xfer_fan_min1;
                mode_next = pbdi_pkg::MODE_CLEANING;
            end
        end
    end

    // Hold controller state; update on each tick, reload lamp test on write in lamp test mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pbdi_pkg::MODE_LAMPTEST;
            ol_reg   <= pbdi_pkg::OUT_RESET;
            td_reg   <= 6'd0;
            fan_reg  <= 7'd0;
            to_reg   <= 4'd0;
            arm_reg  <= 1'b0;
            lt_reg   <= pbdi_pkg::LAMP_TEST_RST;
            dwo_reg  <= 1'b0;
            rl_reg   <= 5'd0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            ol_reg   <= ol_next;
            td_reg   <= td_next;
            fan_reg  <= fan_next;
            to_reg   <= to_next;
            arm_reg  <= arm_next;
            lt_reg   <= lt_next;
            dwo_reg  <= dwo_next;
            rl_reg   <= rl_next;
        end
        else if (lt_load.en && mode_reg == pbdi_pkg::MODE_LAMPTEST)
        begin
            lt_reg <= lt_load.value;
        end
    end

    assign out_levels = ol_reg;
    assign mode       = mode_reg;

endmodule

[design/pass_box_door_interlock.sv]
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_stall   green_button_a, green_button_b, red_button,
//                                 door_open_a, door_open_b
// out       out_valid / out_stall lock_a, lock_b, fan_on, lamp_a_enabled,
//                                 lamp_a_disabled, lamp_b_enabled, lamp_b_disabled,
//                                 mode_now
// cfg       cfg_we                cfg_index, cfg_data
//
// One tick per cycle sustained while out_stall does not hold the result; a tick's
// result is registered in the input register, then in the controller state that drives out.
// The whole tick update is one combinational pass between those registers.
// rst_n is asynchronous and active low; it restores lamp test and config defaults.
// out_stall holds the result and, once the input register is full, raises in_stall.

module pass_box_door_interlock (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       green_button_a,
    input  logic       green_button_b,
    input  logic       red_button,
    input  logic       door_open_a,
    input  logic       door_open_b,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       lock_a,
    output logic       lock_b,
    output logic       fan_on,
    output logic       lamp_a_enabled,
    output logic       lamp_a_disabled,
    output logic       lamp_b_enabled,
    output logic       lamp_b_disabled,
    output logic [2:0] mode_now,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [6:0] cfg_data
);

    logic                               s1_valid_reg;
    logic [pbdi_pkg::NUM_INPUTS-1:0]    s1_raw_reg;
    logic                               out_valid_reg;
    logic                               advance;
    logic [pbdi_pkg::NUM_INPUTS-1:0]    levels;
    logic [6:0]                         ol;
    pbdi_pkg::cfg_t                     cfg_reg;
    pbdi_pkg::lt_load_t                 lt_load;

    // Move the input register forward when the result slot is free or taken
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    // Capture one tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_raw_reg <= {door_open_b, door_open_a, red_button, green_button_b,
                           green_button_a};
        end
    end

    // Result valid: set on advance, drop once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_samples     <= pbdi_pkg::DEBOUNCE_RST;
            cfg_reg.ticks_per_second     <= pbdi_pkg::TICKS_PER_S_RST;
            cfg_reg.transfer_fan_seconds <= pbdi_pkg::XFER_FAN_RST;
            cfg_reg.clean_fan_seconds    <= pbdi_pkg::CLEAN_FAN_RST;
            cfg_reg.open_timeout_seconds <= pbdi_pkg::OPEN_TIMEOUT_RST;
            cfg_reg.lamp_test_seconds    <= pbdi_pkg::LAMP_TEST_RST;
            cfg_reg.relock_delay_ticks   <= pbdi_pkg::RELOCK_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pbdi_pkg::REG_DEBOUNCE:     cfg_reg.debounce_samples     <= cfg_data[4:0];
                pbdi_pkg::REG_TICKS_PER_S:  cfg_reg.ticks_per_second     <= cfg_data[5:0];
                pbdi_pkg::REG_XFER_FAN:     cfg_reg.transfer_fan_seconds <= cfg_data;
                pbdi_pkg::REG_CLEAN_FAN:    cfg_reg.clean_fan_seconds    <= cfg_data;
                pbdi_pkg::REG_OPEN_TIMEOUT: cfg_reg.open_timeout_seconds <= cfg_data[3:0];
                pbdi_pkg::REG_LAMP_TEST:    cfg_reg.lamp_test_seconds    <= cfg_data[1:0];
                pbdi_pkg::REG_RELOCK_DELAY: cfg_reg.relock_delay_ticks   <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    assign lt_load.en    = cfg_we && (cfg_index == pbdi_pkg::REG_LAMP_TEST);
    assign lt_load.value = cfg_data[1:0];

    pbdi_debounce u_debounce (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .raw        (s1_raw_reg),
        .samples    (cfg_reg.debounce_samples),
        .level_next (levels)
    );

    pbdi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .levels     (levels),
        .cfg        (cfg_reg),
        .lt_load    (lt_load),
        .out_levels (ol),
        .mode       (mode_now)
    );

    assign out_valid       = out_valid_reg;
    assign lock_a          = ol[pbdi_pkg::OB_LOCK_A];
    assign lock_b          = ol[pbdi_pkg::OB_LOCK_B];
    assign fan_on          = ol[pbdi_pkg::OB_FAN];
    assign lamp_a_enabled  = ol[pbdi_pkg::OB_AE];
    assign lamp_a_disabled = ol[pbdi_pkg::OB_AD];
    assign lamp_b_enabled  = ol[pbdi_pkg::OB_BE];
    assign lamp_b_disabled = ol[pbdi_pkg::OB_BD];

endmodule

[design/pbdi_checker.sv]
`timescale 1ns / 1ps

module pbdi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       green_button_a,
    input logic       green_button_b,
    input logic       red_button,
    input logic       door_open_a,
    input logic       door_open_b,
    input logic       out_valid,
    input logic       out_stall,
    input logic       lock_a,
    input logic       lock_b,
    input logic       fan_on,
    input logic       lamp_a_enabled,
    input logic       lamp_a_disabled,
    input logic       lamp_b_enabled,
    input logic       lamp_b_disabled,
    input logic [2:0] mode_now,
    input logic       cfg_we,
    input logic [2:0] cfg_index,
    input logic [6:0] cfg_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(mode_now) && $stable(lock_a) &&
                                   $stable(lock_b) && $stable(fan_on))
        else $error("stalled result changed");

    // A fresh result follows a tick transferred into the input register
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching tick");

    // Cleaning always runs the fan
    a_clean_fan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_now == pbdi_pkg::MODE_CLEANING |-> fan_on)
        else $error("cleaning mode with fan off");

    // Lamp test shows everything on and the doors free
    a_lamp_test: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_now == pbdi_pkg::MODE_LAMPTEST |->
            fan_on && lamp_a_enabled && lamp_a_disabled && lamp_b_enabled &&
            lamp_b_disabled && !lock_a && !lock_b)
        else $error("lamp test levels wrong");

endmodule

bind pass_box_door_interlock pbdi_checker u_pbdi_checker (.*);
